// File: design/fpa_pkg.sv
// Shared types, constants and opcodes for the Q24.8 fixed-point ALU.
package fpa_pkg;
   localparam int WordWidth = 32;
   localparam int FracBits  = 8;
   localparam int DivSteps  = WordWidth + FracBits;
   localparam int QuotWidth = WordWidth + FracBits;

   typedef enum logic [3:0] {
      FN_ADD = 4'd0, FN_SUB = 4'd1, FN_MUL = 4'd2, FN_DIV = 4'd3,
      FN_LT = 4'd4, FN_GT = 4'd5, FN_LE = 4'd6, FN_GE = 4'd7,
      FN_EQ = 4'd8, FN_NE = 4'd9, FN_MIN = 4'd10, FN_MAX = 4'd11,
      FN_INC = 4'd12, FN_DEC = 4'd13, FN_I2F = 4'd14, FN_F2I = 4'd15
   } func_type;

   typedef enum logic [1:0] {
      ERR_NONE = 2'd0, ERR_DIV_ZERO = 2'd1, ERR_SAT = 2'd2
   } err_type;

   typedef logic [WordWidth-1:0] word_type;

   // Side information that rides along the pipeline with each beat.
   typedef struct packed {
      func_type func;
      logic     neg;
      logic     div_zero;
      word_type simple;
      logic     cmp;
   } ctl_type;
endpackage

// File: design/fpa_div_stage.sv
// One restoring-division step of the unsigned quotient pipeline.
module fpa_div_stage (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic [fpa_pkg::WordWidth:0]           rem_in_d,
   input  logic [fpa_pkg::QuotWidth-1:0]         quo_in_d,
   input  logic [fpa_pkg::WordWidth-1:0]         dvs_in_d,
   output logic [fpa_pkg::WordWidth:0]           rem_q,
   output logic [fpa_pkg::QuotWidth-1:0]         quo_q,
   output logic [fpa_pkg::WordWidth-1:0]         dvs_q
);
   import fpa_pkg::*;
   logic [WordWidth:0]   shifted;
   logic [WordWidth+1:0] diff;
   logic [WordWidth:0]   rem_ff, rem_in;
   logic [QuotWidth-1:0] quo_ff, quo_in;
   logic [WordWidth-1:0] dvs_ff;

   always_comb begin
      shifted = {rem_in_d[WordWidth-1:0], quo_in_d[QuotWidth-1]};
      diff    = {1'b0, shifted} - {2'b00, dvs_in_d};
      if (!diff[WordWidth+1]) begin
         rem_in = diff[WordWidth:0];
         quo_in = {quo_in_d[QuotWidth-2:0], 1'b1};
      end else begin
         rem_in = shifted;
         quo_in = {quo_in_d[QuotWidth-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         dvs_ff <= dvs_in_d;
      end
   end

   assign rem_q = rem_ff;
   assign quo_q = quo_ff;
   assign dvs_q = dvs_ff;
endmodule

// File: design/fpa_divider.sv
// Pipelined magnitude divider: one quotient bit per stage, then rounding.
module fpa_divider (
   input  logic                           clock,
   input  logic                           en,
   input  logic [fpa_pkg::WordWidth-1:0]  num_mag,
   input  logic [fpa_pkg::WordWidth-1:0]  den_mag,
   output logic [fpa_pkg::QuotWidth:0]    quo_rounded
);
   import fpa_pkg::*;
   logic [WordWidth:0]   rem_s [0:DivSteps];
   logic [QuotWidth-1:0] quo_s [0:DivSteps];
   logic [WordWidth-1:0] dvs_s [0:DivSteps];
   logic [WordWidth+1:0] twice_rem;

   // The dividend is shifted in through the quotient register.
   assign rem_s[0] = '0;
   assign quo_s[0] = {num_mag, {FracBits{1'b0}}};
   assign dvs_s[0] = den_mag;

   for (genvar g = 0; g < DivSteps; g++) begin : g_step
      fpa_div_stage u_stage (
         .clock    (clock),
         .en       (en),
         .rem_in_d (rem_s[g]),
         .quo_in_d (quo_s[g]),
         .dvs_in_d (dvs_s[g]),
         .rem_q    (rem_s[g+1]),
         .quo_q    (quo_s[g+1]),
         .dvs_q    (dvs_s[g+1])
      );
   end

   // Round half away from zero: bump when twice the remainder reaches the divisor.
   assign twice_rem   = {rem_s[DivSteps], 1'b0};
   assign quo_rounded = {1'b0, quo_s[DivSteps]}
                      + {{QuotWidth{1'b0}}, (twice_rem >= {2'b00, dvs_s[DivSteps]})};
endmodule

// File: design/fixed_point_alu_q24_8_unit.sv
// Top level of the Q24.8 fixed-point ALU pipeline.
//
// Input beats arrive on req_ (tdata: func, operand_a, operand_b from bit 0 up)
// and results leave on rsp_ (tdata: result, compare_true, error from bit 0 up).
// Every opcode goes through the same pipeline, so order is kept and one beat
// may enter every cycle. From acceptance to rsp_tvalid a beat passes through
// one input stage that also forms the full 32x32 product, 40 divider stages
// (one quotient bit per stage, the product riding alongside), then rounding
// and saturation in front of the output register. The 40-step divider sets
// the pipeline depth.
// The pipeline advances as a whole; when rsp_tready is low and the output
// register is full, every stage holds and req_tready drops, so nothing is
// lost or repeated. Empty slots in the pipeline are not squeezed out:
// req_tready stays high exactly while the output is free or being taken.
// Synchronous reset clears all valid bits; data registers are not reset.
module fixed_point_alu_q24_8_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // func[3:0], operand_a[35:4], operand_b[67:36], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // result[31:0], compare_true[32], error[34:33], zero
);
   import fpa_pkg::*;
   localparam int Depth = DivSteps + 2;

   logic                 en;
   logic [Depth-1:0]     vld_ff, vld_in;
   ctl_type              ctl_s [0:DivSteps];
   logic [WordWidth-1:0] a0_ff, b0_ff;
   ctl_type              ctl0_ff;
   logic [2*WordWidth-1:0] prod_ff;
   logic [2*WordWidth-1:0] prod_d [0:DivSteps];
   logic [QuotWidth:0]   quo_rnd;
   word_type             res_ff, res_in;
   logic                 cmp_ff;
   err_type              err_ff, err_in;

   func_type             fn;
   word_type             a, b;
   logic                 an, bn, lt_ab, lt_ba;
   word_type             mag_a, mag_b, simple;
   logic                 cmp;
   ctl_type              ctl_new;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign vld_in     = {vld_ff[Depth-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= vld_in;
   end
   assign rsp_tvalid = vld_ff[Depth-1];

   // Stage 0: decode, simple operations and magnitudes.
   always_comb begin
      fn    = func_type'(req_tdata[3:0]);
      a     = req_tdata[35:4];
      b     = req_tdata[67:36];
      an    = a[WordWidth-1];
      bn    = b[WordWidth-1];
      lt_ab = $signed(a) < $signed(b);
      lt_ba = $signed(b) < $signed(a);
      mag_a = an ? (~a + 1'b1) : a;
      mag_b = bn ? (~b + 1'b1) : b;
      simple = '0;
      cmp    = 1'b0;
      case (fn)
         FN_ADD: simple = a + b;
         FN_SUB: simple = a - b;
         FN_LT:  cmp = lt_ab;
         FN_GT:  cmp = lt_ba;
         FN_LE:  cmp = !lt_ba;
         FN_GE:  cmp = !lt_ab;
         FN_EQ:  cmp = (a == b);
         FN_NE:  cmp = (a != b);
         FN_MIN: simple = lt_ba ? b : a;
         FN_MAX: simple = lt_ab ? b : a;
         FN_INC: simple = a + 1'b1;
         FN_DEC: simple = a - 1'b1;
         FN_I2F: simple = {an | a[WordWidth-1-FracBits], a[WordWidth-2-FracBits:0],
                           {FracBits{1'b0}}};
         FN_F2I: begin
            simple = mag_a >> FracBits;
            if (an) simple = ~simple + 1'b1;
         end
         default: simple = '0;
      endcase
      ctl_new.func     = fn;
      ctl_new.neg      = an ^ bn;
      ctl_new.div_zero = (b == '0);
      ctl_new.simple   = simple;
      ctl_new.cmp      = cmp;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl0_ff <= ctl_new;
         a0_ff   <= mag_a;
         b0_ff   <= mag_b;
         prod_ff <= 64'(mag_a) * 64'(mag_b);
      end
   end

   fpa_divider u_div (
      .clock       (clock),
      .en          (en),
      .num_mag     (a0_ff),
      .den_mag     (b0_ff),
      .quo_rounded (quo_rnd)
   );

   // Control and product travel beside the divider stages.
   assign ctl_s[0]  = ctl0_ff;
   assign prod_d[0] = prod_ff;
   for (genvar g = 0; g < DivSteps; g++) begin : g_side
      ctl_type                ctl_ff;
      logic [2*WordWidth-1:0] p_ff;
      always_ff @(posedge clock) begin
         if (en) begin
            ctl_ff <= ctl_s[g];
            p_ff   <= prod_d[g];
         end
      end
      assign ctl_s[g+1]  = ctl_ff;
      assign prod_d[g+1] = p_ff;
   end

   // Round the product, flag divide by zero, saturate, and pick the result.
   logic [2*WordWidth:0]   prod_r;
   logic [2*WordWidth:0]   mag;
   logic [WordWidth-1:0]   limit;
   ctl_type                cl;
   always_comb begin
      cl     = ctl_s[DivSteps];
      prod_r = ({1'b0, prod_d[DivSteps]} + (65'd1 << (FracBits - 1))) >> FracBits;
      mag    = (cl.func == FN_MUL) ? prod_r : (2*WordWidth+1)'(quo_rnd);
      limit  = cl.neg ? {1'b1, {(WordWidth-1){1'b0}}} : {1'b0, {(WordWidth-1){1'b1}}};
      res_in = cl.simple;
      err_in = ERR_NONE;
      if (cl.func == FN_MUL || cl.func == FN_DIV) begin
         if (cl.func == FN_DIV && cl.div_zero) begin
            res_in = '0;
            err_in = ERR_DIV_ZERO;
         end else if (mag > (2*WordWidth+1)'(limit)) begin
            res_in = limit;
            err_in = ERR_SAT;
         end else begin
            res_in = cl.neg ? (~mag[WordWidth-1:0] + 1'b1) : mag[WordWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
         cmp_ff <= cl.cmp;
         err_ff <= err_in;
      end
   end

   assign rsp_tdata = {5'b0, err_ff, cmp_ff, res_ff};
endmodule

// File: design/fpa_checker.sv
// Port-level checker for the fixed-point ALU, bound to the top level.
module fpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[34:33] != 2'd3 && !(rsp_tdata[32] && rsp_tdata[34:33] != 2'd0))
      else $error("bad error code");
endmodule

bind fixed_point_alu_q24_8_unit fpa_checker u_fpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: sim/tb.sv
// Self-checking testbench for the Q24.8 fixed-point ALU: random and directed beats.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fpa_pkg::*;

   typedef struct packed {
      logic [1:0]  err;
      logic        cmp;
      logic [31:0] result;
   } alu_out_type;

   // Predicts each ALU answer and checks results in order against it.
   class alu_scoreboard;
      alu_out_type pending[$];
      int errors;
      int checked;

      function logic [31:0] mag(logic [31:0] x);
         mag = x[31] ? -x : x;
      endfunction

      function alu_out_type sat(logic [127:0] m, logic neg);
         alu_out_type o;
         logic [127:0] lim;
         o = '0;
         lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
         if (m > lim) begin
            o.err = ERR_SAT;
            o.result = neg ? 32'h8000_0000 : 32'h7fff_ffff;
         end else begin
            o.result = neg ? -m[31:0] : m[31:0];
         end
         return o;
      endfunction

      function alu_out_type compute(func_type f, logic [31:0] a, logic [31:0] b);
         alu_out_type o;
         logic [127:0] m, n, q, r, d;
         logic neg;
         o = '0;
         neg = a[31] ^ b[31];
         case (f)
            FN_ADD: o.result = a + b;
            FN_SUB: o.result = a - b;
            FN_MUL: begin
               m = 128'(mag(a)) * 128'(mag(b));
               m = (m + 128'(1 << (FracBits - 1))) >> FracBits;
               o = sat(m, neg);
            end
            FN_DIV: begin
               if (b == 0) begin
                  o.err = ERR_DIV_ZERO;
               end else begin
                  d = 128'(mag(b));
                  n = 128'(mag(a)) << FracBits;
                  q = n / d;
                  r = n % d;
                  if (r >= d - r) q = q + 1;
                  o = sat(q, neg);
               end
            end
            FN_LT: o.cmp = $signed(a) < $signed(b);
            FN_GT: o.cmp = $signed(a) > $signed(b);
            FN_LE: o.cmp = $signed(a) <= $signed(b);
            FN_GE: o.cmp = $signed(a) >= $signed(b);
            FN_EQ: o.cmp = a == b;
            FN_NE: o.cmp = a != b;
            FN_MIN: o.result = ($signed(b) < $signed(a)) ? b : a;
            FN_MAX: o.result = ($signed(a) < $signed(b)) ? b : a;
            FN_INC: o.result = a + 1;
            FN_DEC: o.result = a - 1;
            FN_I2F: o.result = (a << FracBits) | {a[31], 31'b0};
            default: o.result = a[31] ? -(mag(a) >> FracBits) : (mag(a) >> FracBits);
         endcase
         return o;
      endfunction

      function void note_request(func_type f, logic [31:0] a, logic [31:0] b);
         pending.push_back(compute(f, a, b));
      endfunction

      function void check_response(logic [39:0] data);
         alu_out_type want, got;
         got = data[34:0];
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.result !== want.result)
            $display("%0t: result expected %h actual %h", $time, want.result, got.result);
         if (got.cmp !== want.cmp)
            $display("%0t: compare_true expected %b actual %b", $time, want.cmp, got.cmp);
         if (got.err !== want.err)
            $display("%0t: error expected %0d actual %0d", $time, want.err, got.err);
         if (got !== want || data[39:35] !== 5'b0) errors++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [71:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   alu_scoreboard alu_sb = new();
   int cycles = 0;
   int sent = 0;
   bit stim_done = 0;
   bit hold_off = 0;

   always #10 clock = ~clock;

   fixed_point_alu_q24_8_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_tvalid && req_tready)
         alu_sb.note_request(func_type'(req_tdata[3:0]), req_tdata[35:4], req_tdata[67:36]);
      if (!reset && rsp_tvalid && rsp_tready) alu_sb.check_response(rsp_tdata);
      if (cycles > 400000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function int gap_len();
      int p;
      p = $urandom_range(99);
      if (p < 60) return 0;
      if (p < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 5);
   endfunction

   function logic [31:0] rand_word();
      case ($urandom_range(7))
         0: return 32'h8000_0000 + $urandom_range(3);
         1: return 32'h7fff_ffff - $urandom_range(3);
         2: return $urandom_range(600) - 300;
         3: return $urandom_range(1 << 16) - (1 << 15);
         4: return {$urandom_range(1) ? 8'hff : 8'h00, 24'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // Offers one beat and holds it until the ALU takes it.
   task automatic send_beat(func_type f, logic [31:0] a, logic [31:0] b);
      int g;
      g = gap_len();
      repeat (g) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, b, a, f};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   // Receiver: random stalls, plus one long hold-off when requested.
   initial begin
      int g;
      @(negedge clock);
      while (1) begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         g = gap_len();
         if (g == 0) begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (g) @(negedge clock);
         end
      end
   end

   initial begin
      logic [31:0] edge_vals[8];
      edge_vals = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                    32'h100, 32'hffff_ff00, 32'h80};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Directed: every opcode on the extremes, plus divide by zero and tiny negatives.
      for (int f = 0; f < 16; f++)
         send_beat(func_type'(f), edge_vals[f % 8], edge_vals[(f + 3) % 8]);
      send_beat(FN_DIV, 32'h100, 32'h0);
      send_beat(FN_DIV, 32'h8000_0000, 32'h1);
      send_beat(FN_MUL, 32'h8000_0000, 32'h8000_0000);
      send_beat(FN_MUL, 32'hffff_ffff, 32'h1);
      send_beat(FN_DIV, 32'hffff_ffff, 32'h7fff_ffff);
      send_beat(FN_MUL, 32'h80, 32'h1);
      send_beat(FN_I2F, 32'hffff_ffff, 32'h0);
      send_beat(FN_F2I, 32'hffff_ff01, 32'h0);
      for (int i = 0; i < 1600; i++) begin
         if (i == 400) hold_off = 1;
         send_beat(func_type'($urandom_range(15)), rand_word(),
                   ($urandom_range(30) == 0) ? 32'h0 : rand_word());
      end
      req_tvalid <= 1'b0;
      while (alu_sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Sent %0d beats over all 16 opcodes; %0d results checked.", sent,
               alu_sb.checked);
      $display("Covered operand extremes, saturation, divide by zero and backpressure.");
      if (alu_sb.errors == 0 && alu_sb.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
